// File: src/hrnt_pkg.sv
// Shared types and codes for the hash ring node table.
package hrnt_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  // Result payload source
  localparam logic [1:0] SEL_ZERO  = 2'd0;
  localparam logic [1:0] SEL_RDATA = 2'd1;
  localparam logic [1:0] SEL_FIRST = 2'd2;

  // Function codes
  localparam logic FUNC_REGISTER = 1'b0;
  localparam logic FUNC_LOOKUP   = 1'b1;

  localparam int IdW   = 64;
  localparam int PortW = 16;
  localparam int CapW  = 5;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       clr_k;
    logic       inc_k;
    logic       dec_k;
    logic       set_k_count;
    logic       set_pos_k;
    logic       set_pos_count;
    logic       rd_k;
    logic       rd_km1;
    logic       wr_shift;
    logic       wr_ins;
    logic       cap_first;
    logic       set_res;
    logic [1:0] res_status;
    logic [1:0] res_sel;
    logic       out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic func;
    logic full;
    logic not_ready;
    logic empty;
    logic eq;
    logic gt;
    logic k_zero;
    logic k_last;
    logic k_gt_pos;
    logic out_free;
  } stat_t;

endpackage

// File: src/hash_ring_node_table.sv
// Top level of the consistent-hash ring node table.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o    | func_i, node_id_i, node_port_i, key_hash_i
//  out     | out_valid_o / out_stall_i  | status_o, owner_id_o, owner_port_o, owner_slot_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_data_i (node capacity)
//
// One item at a time; each entry scanned is read, then compared. A lookup scans
// from slot zero up to the first ID above its key; a register scans to its insert
// position, then shifts each later entry up by one (read, write) before the insert;
// a refused item goes straight to its result.
// Reset empties the table at once (count cleared) and sets capacity to 16. A stalled
// result holds in the output register; the next item's result waits until it frees.
module hash_ring_node_table #(
  parameter int MAX_NODES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [hrnt_pkg::IdW-1:0]   node_id_i,
  input  logic [hrnt_pkg::PortW-1:0] node_port_i,
  input  logic [hrnt_pkg::IdW-1:0]   key_hash_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [hrnt_pkg::IdW-1:0]   owner_id_o,
  output logic [hrnt_pkg::PortW-1:0] owner_port_o,
  output logic [3:0]                 owner_slot_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hrnt_pkg::CapW-1:0]  cfg_data_i
);

  hrnt_pkg::cmd_t  cmd;
  hrnt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  hrnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hrnt_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .node_id_i    (node_id_i),
    .node_port_i  (node_port_i),
    .key_hash_i   (key_hash_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .owner_id_o   (owner_id_o),
    .owner_port_o (owner_port_o),
    .owner_slot_o (owner_slot_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

// File: src/hrnt_ctrl.sv
// Sequencer for registration and lookup over the sorted node table.
module hrnt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hrnt_pkg::stat_t stat_i,
  output hrnt_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;
  localparam logic [2:0] S_INS  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.func == hrnt_pkg::FUNC_REGISTER) begin
          if (stat_i.full) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = hrnt_pkg::ST_FULL;
            cmd_o.res_sel    = hrnt_pkg::SEL_ZERO;
            state_d          = S_DONE;
          end else if (stat_i.empty) begin
            // empty table: insert straight into slot zero
            cmd_o.set_pos_count = 1'b1;
            cmd_o.set_k_count   = 1'b1;
            state_d             = S_SHRD;
          end else begin
            cmd_o.clr_k = 1'b1;
            state_d     = S_RD;
          end
        end else begin
          if (stat_i.not_ready) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = hrnt_pkg::ST_NOT_READY;
            cmd_o.res_sel    = hrnt_pkg::SEL_ZERO;
            state_d          = S_DONE;
          end else begin
            cmd_o.clr_k = 1'b1;
            state_d     = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_k = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        cmd_o.cap_first = stat_i.k_zero;
        if (stat_i.func == hrnt_pkg::FUNC_REGISTER) begin
          if (stat_i.eq) begin
            // duplicate ID: success, table unchanged
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = hrnt_pkg::ST_OK;
            cmd_o.res_sel    = hrnt_pkg::SEL_ZERO;
            state_d          = S_DONE;
          end else if (stat_i.gt) begin
            cmd_o.set_pos_k   = 1'b1;
            cmd_o.set_k_count = 1'b1;
            state_d           = S_SHRD;
          end else if (stat_i.k_last) begin
            cmd_o.set_pos_count = 1'b1;
            cmd_o.set_k_count   = 1'b1;
            state_d             = S_SHRD;
          end else begin
            cmd_o.inc_k = 1'b1;
            state_d     = S_RD;
          end
        end else begin
          if (stat_i.gt) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = hrnt_pkg::ST_OK;
            cmd_o.res_sel    = hrnt_pkg::SEL_RDATA;
            state_d          = S_DONE;
          end else if (stat_i.k_last) begin
            // wrap round to the lowest node
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = hrnt_pkg::ST_OK;
            cmd_o.res_sel    = hrnt_pkg::SEL_FIRST;
            state_d          = S_DONE;
          end else begin
            cmd_o.inc_k = 1'b1;
            state_d     = S_RD;
          end
        end
      end
      S_SHRD: begin
        if (stat_i.k_gt_pos) begin
          cmd_o.rd_km1 = 1'b1;
          state_d      = S_SHWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.dec_k    = 1'b1;
        state_d        = S_SHRD;
      end
      S_INS: begin
        cmd_o.wr_ins     = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = hrnt_pkg::ST_OK;
        cmd_o.res_sel    = hrnt_pkg::SEL_ZERO;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/hrnt_datapath.sv
// Node table memory, scan index, item and result registers.
module hrnt_datapath #(
  parameter int MAX_NODES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            func_i,
  input  logic [hrnt_pkg::IdW-1:0]        node_id_i,
  input  logic [hrnt_pkg::PortW-1:0]      node_port_i,
  input  logic [hrnt_pkg::IdW-1:0]        key_hash_i,
  input  logic                            cfg_valid_i,
  input  logic [hrnt_pkg::CapW-1:0]       cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [1:0]                      status_o,
  output logic [hrnt_pkg::IdW-1:0]        owner_id_o,
  output logic [hrnt_pkg::PortW-1:0]      owner_port_o,
  output logic [3:0]                      owner_slot_o,
  input  hrnt_pkg::cmd_t                  cmd_i,
  output hrnt_pkg::stat_t                 stat_o
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = (CW > hrnt_pkg::CapW) ? CW : hrnt_pkg::CapW;
  localparam int DW = hrnt_pkg::IdW + hrnt_pkg::PortW;

  // Item, config and control registers
  logic                       func_q;
  logic [hrnt_pkg::IdW-1:0]   id_q, key_q;
  logic [hrnt_pkg::PortW-1:0] port_q;
  logic [hrnt_pkg::CapW-1:0]  cap_q;
  logic [CW-1:0]              count_q, k_q, pos_q;
  logic [hrnt_pkg::IdW-1:0]   first_id_q;
  logic [hrnt_pkg::PortW-1:0] first_port_q;
  logic [1:0]                 res_status_q, res_sel_q;
  logic                       out_valid_q;
  logic [1:0]                 status_q;
  logic [hrnt_pkg::IdW-1:0]   owner_id_q;
  logic [hrnt_pkg::PortW-1:0] owner_port_q;
  logic [3:0]                 owner_slot_q;

  // Table memory
  logic [DW-1:0] mem_q [MAX_NODES];
  logic [DW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata;
  logic [CW-1:0] k_m1;

  logic [hrnt_pkg::IdW-1:0]   rid;
  logic [hrnt_pkg::PortW-1:0] rport;
  logic [hrnt_pkg::IdW-1:0]   cmp_val;
  logic [EW-1:0]              cnt_x, cap_x, k_x;

  assign rid     = rdata_q[DW-1:hrnt_pkg::PortW];
  assign rport   = rdata_q[hrnt_pkg::PortW-1:0];
  assign cmp_val = (func_q == hrnt_pkg::FUNC_LOOKUP) ? key_q : id_q;
  assign k_m1    = k_q - CW'(1);
  assign cnt_x   = EW'(count_q);
  assign cap_x   = EW'(cap_q);
  assign k_x     = EW'(k_q);

  assign we    = cmd_i.wr_shift | cmd_i.wr_ins;
  assign re    = cmd_i.rd_k | cmd_i.rd_km1;
  assign waddr = cmd_i.wr_ins ? pos_q[AW-1:0] : k_q[AW-1:0];
  assign wdata = cmd_i.wr_ins ? {id_q, port_q} : rdata_q;
  assign raddr = cmd_i.rd_km1 ? k_m1[AW-1:0] : k_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.func      = func_q;
    stat_o.full      = (cnt_x == cap_x) || (count_q >= CW'(MAX_NODES));
    stat_o.not_ready = (cnt_x < cap_x) || (count_q == '0);
    stat_o.empty     = (count_q == '0);
    stat_o.eq        = (rid == cmp_val);
    stat_o.gt        = (rid > cmp_val);
    stat_o.k_zero    = (k_q == '0);
    stat_o.k_last    = ((k_q + CW'(1)) == count_q);
    stat_o.k_gt_pos  = (k_q > pos_q);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Item capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q   <= node_id_i;
      port_q <= node_port_i;
      key_q  <= key_hash_i;
    end
    if (cmd_i.cap_first) begin
      first_id_q   <= rid;
      first_port_q <= rport;
    end
    if (cmd_i.set_pos_k) begin
      pos_q <= k_q;
    end else if (cmd_i.set_pos_count) begin
      pos_q <= count_q;
    end
    if (cmd_i.clr_k) begin
      k_q <= '0;
    end else if (cmd_i.set_k_count) begin
      k_q <= count_q;
    end else if (cmd_i.inc_k) begin
      k_q <= k_q + CW'(1);
    end else if (cmd_i.dec_k) begin
      k_q <= k_m1;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_sel_q    <= cmd_i.res_sel;
    end
  end

  // Node count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= hrnt_pkg::CAP_RESET;
    end else begin
      if (cmd_i.wr_ins) begin
        count_q <= count_q + CW'(1);
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= res_status_q;
      case (res_sel_q)
        hrnt_pkg::SEL_RDATA: begin
          owner_id_q   <= rid;
          owner_port_q <= rport;
          owner_slot_q <= k_x[3:0];
        end
        hrnt_pkg::SEL_FIRST: begin
          owner_id_q   <= first_id_q;
          owner_port_q <= first_port_q;
          owner_slot_q <= '0;
        end
        default: begin
          owner_id_q   <= '0;
          owner_port_q <= '0;
          owner_slot_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign owner_id_o   = owner_id_q;
  assign owner_port_o = owner_port_q;
  assign owner_slot_o = owner_slot_q;

endmodule

// File: tb/sv/hash_ring_node_table_tb.sv
// Self-checking testbench for the hash ring node table: directed and random items.
module hash_ring_node_table_tb;

  localparam int MaxNodes = 16;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int DrainCycles = 100;
  localparam int PhaseItems = 250;

  typedef struct packed {
    logic [1:0]                 status;
    logic [hrnt_pkg::IdW-1:0]   owner_id;
    logic [hrnt_pkg::PortW-1:0] owner_port;
    logic [3:0]                 owner_slot;
  } reply_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       func_i = hrnt_pkg::FUNC_REGISTER;
  logic [hrnt_pkg::IdW-1:0]   node_id_i = '0;
  logic [hrnt_pkg::PortW-1:0] node_port_i = '0;
  logic [hrnt_pkg::IdW-1:0]   key_hash_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 status_o;
  logic [hrnt_pkg::IdW-1:0]   owner_id_o;
  logic [hrnt_pkg::PortW-1:0] owner_port_o;
  logic [3:0]                 owner_slot_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [hrnt_pkg::CapW-1:0]  cfg_data_i = '0;

  // Shadow copy of the ring and its capacity
  logic [hrnt_pkg::IdW-1:0]   ring_id_q [MaxNodes];
  logic [hrnt_pkg::PortW-1:0] ring_port_q [MaxNodes];
  int                         node_count = 0;
  logic [hrnt_pkg::CapW-1:0]  capacity = hrnt_pkg::CAP_RESET;

  reply_t      replies_due [$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;

  hash_ring_node_table #(
    .MAX_NODES(MaxNodes)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .node_id_i   (node_id_i),
    .node_port_i (node_port_i),
    .key_hash_i  (key_hash_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .owner_id_o  (owner_id_o),
    .owner_port_o(owner_port_o),
    .owner_slot_o(owner_slot_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly short idle spells, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [hrnt_pkg::IdW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // An ID currently held in the ring, or a random word if the ring is empty
  function automatic logic [hrnt_pkg::IdW-1:0] stored_id();
    if (node_count == 0) return rand_word();
    return ring_id_q[$urandom_range(0, node_count - 1)];
  endfunction

  // Reply of the table to one item; updates the shadow ring on a register
  function automatic reply_t node_table_reply(logic f, logic [hrnt_pkg::IdW-1:0] id,
                                              logic [hrnt_pkg::PortW-1:0] port,
                                              logic [hrnt_pkg::IdW-1:0] key);
    reply_t r;
    int     pos;
    int     slot;
    bit     dup;
    r = '0;
    if (f == hrnt_pkg::FUNC_REGISTER) begin
      // full test comes before the duplicate test
      if (node_count == capacity || node_count >= MaxNodes) begin
        r.status = hrnt_pkg::ST_FULL;
      end else begin
        pos = node_count;
        dup = 1'b0;
        for (int k = 0; k < node_count; k++) begin
          if (ring_id_q[k] == id) begin
            dup = 1'b1;
            break;
          end
          if (ring_id_q[k] > id) begin
            pos = k;
            break;
          end
        end
        // a duplicate leaves the table and its port alone
        if (!dup) begin
          for (int k = node_count; k > pos; k--) begin
            ring_id_q[k]   = ring_id_q[k-1];
            ring_port_q[k] = ring_port_q[k-1];
          end
          ring_id_q[pos]   = id;
          ring_port_q[pos] = port;
          node_count++;
        end
        r.status = hrnt_pkg::ST_OK;
      end
    end else if (node_count < capacity || node_count == 0) begin
      r.status = hrnt_pkg::ST_NOT_READY;
    end else begin
      // first ID above the key, else wrap to the lowest node
      slot = 0;
      for (int k = 0; k < node_count; k++) begin
        if (ring_id_q[k] > key) begin
          slot = k;
          break;
        end
      end
      r.status     = hrnt_pkg::ST_OK;
      r.owner_id   = ring_id_q[slot];
      r.owner_port = ring_port_q[slot];
      r.owner_slot = slot[3:0];
    end
    return r;
  endfunction

  // Present one item and wait for it to be taken; valid stays high for a back-to-back item
  task automatic send_item(input logic f, input logic [hrnt_pkg::IdW-1:0] id,
                           input logic [hrnt_pkg::PortW-1:0] port,
                           input logic [hrnt_pkg::IdW-1:0] key);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    node_id_i   <= id;
    node_port_i <= port;
    key_hash_i  <= key;
    do @(posedge clk_i); while (in_stall_o);
    replies_due.push_back(node_table_reply(f, id, port, key));
  endtask

  task automatic register_node(input logic [hrnt_pkg::IdW-1:0] id,
                               input logic [hrnt_pkg::PortW-1:0] port);
    send_item(hrnt_pkg::FUNC_REGISTER, id, port, rand_word());
  endtask

  task automatic lookup_key(input logic [hrnt_pkg::IdW-1:0] key);
    send_item(hrnt_pkg::FUNC_LOOKUP, rand_word(), hrnt_pkg::PortW'($urandom), key);
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Capacity is only changed with nothing in flight
  task automatic write_capacity(input logic [hrnt_pkg::CapW-1:0] cap);
    wait_until_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity = cap;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_ring();
    lookup_key('0);
    lookup_key('1);
  endtask

  task automatic test_zero_capacity();
    write_capacity(5'd0);
    register_node(64'h0123_4567_89AB_CDEF, 16'h1234);
    lookup_key(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_single_node();
    write_capacity(5'd1);
    register_node(64'h8000_0000_0000_0000, 16'hFFFF);
    register_node('0, 16'h0001);
    // full wins over duplicate
    register_node(64'h8000_0000_0000_0000, 16'h0000);
    lookup_key('0);
    lookup_key(64'h8000_0000_0000_0000);
    lookup_key('1);
  endtask

  task automatic test_capacity_above_max();
    write_capacity(5'd31);
    register_node('0, 16'h0000);
    register_node('1, 16'hFFFF);
    register_node(64'h5555_5555_5555_5555, 16'hAAAA);
    register_node('0, 16'h5A5A);
    lookup_key(64'h4000_0000_0000_0000);
  endtask

  task automatic test_capacity_below_count();
    write_capacity(5'd2);
    register_node(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
    lookup_key('0);
    lookup_key('1);
    lookup_key(64'h5555_5555_5555_5555);
    lookup_key(64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // Phases of mixed traffic, each under its own capacity
  task automatic test_random_traffic();
    logic [hrnt_pkg::CapW-1:0] caps [8] = '{5'd31, 5'd16, 5'd0, 5'd1,
                                            5'd16, 5'd31, 5'd8, 5'd12};
    logic [hrnt_pkg::IdW-1:0]  id;
    logic [hrnt_pkg::IdW-1:0]  key;
    for (int p = 0; p < 8; p++) begin
      write_capacity((p >= 6) ? hrnt_pkg::CapW'($urandom_range(0, 31)) : caps[p]);
      no_idle = (p == 4);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 4))
            0, 1:    id = rand_word();
            2:       id = stored_id();
            3:       id = hrnt_pkg::IdW'($urandom_range(0, 15));
            default: id = $urandom_range(0, 1) ? '1 : '0;
          endcase
          register_node(id, hrnt_pkg::PortW'($urandom));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: key = stored_id();
            4:          key = stored_id() + 1'b1;
            5:          key = stored_id() - 1'b1;
            6, 7:       key = rand_word();
            8:          key = '0;
            default:    key = '1;
          endcase
          lookup_key(key);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side stall pattern
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (run_left != 0) begin
      run_left    <= run_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      run_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : idle_len();
      stall_left  <= idle_len();
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result taken with the oldest reply due
  always @(posedge clk_i) begin
    reply_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        $error("result with none due: status %0d id %h", status_o, owner_id_o);
        fault_count++;
      end else begin
        exp = replies_due.pop_front();
        if (status_o !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status_o);
          fault_count++;
        end
        if (owner_id_o !== exp.owner_id) begin
          $error("owner_id: expected %h, got %h", exp.owner_id, owner_id_o);
          fault_count++;
        end
        if (owner_port_o !== exp.owner_port) begin
          $error("owner_port: expected %h, got %h", exp.owner_port, owner_port_o);
          fault_count++;
        end
        if (owner_slot_o !== exp.owner_slot) begin
          $error("owner_slot: expected %0d, got %0d", exp.owner_slot, owner_slot_o);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_ring();
    test_zero_capacity();
    test_single_node();
    test_capacity_above_max();
    test_capacity_below_count();
    test_random_traffic();
    wait_until_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/hrnt_pkg.sv
src/hrnt_ctrl.sv
src/hrnt_datapath.sv
src/hash_ring_node_table.sv
tb/sv/hash_ring_node_table_tb.sv
